// ===== hw/rtl/float_matrix_multiply_core_defines.svh =====
// assertion macros for the float matrix multiply core
// needs clk and rst_n in the scope where a macro is used
`ifndef FLOAT_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define FLOAT_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// same-cycle implication
`define FMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fmm_pkg.sv =====
// shared types, codes and constants of the float matrix multiply core
// no dependencies
`default_nettype none
package fmm_pkg;

  localparam int MaxDimDefault = 4;
  localparam int CfgW          = 3;
  localparam int DimW          = 4;
  localparam int PaddrW        = 4;

  localparam logic [1:0] FuncLoadLeft  = 2'd0;
  localparam logic [1:0] FuncLoadRight = 2'd1;
  localparam logic [1:0] FuncCompute   = 2'd2;

  localparam logic [1:0] RegLeftRows  = 2'd0;
  localparam logic [1:0] RegInnerSize = 2'd1;
  localparam logic [1:0] RegRightCols = 2'd2;

  localparam logic [CfgW-1:0] DimReset = 3'd4;

  localparam logic [31:0] FpQnan    = 32'h7FC0_0000;
  localparam logic [31:0] FpInf     = 32'h7F80_0000;
  localparam logic [31:0] FpPosZero = 32'h0000_0000;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_READ, SEQ_MUL, SEQ_MUL_WAIT, SEQ_ADD, SEQ_ADD_WAIT, SEQ_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {FPU_IDLE, FPU_NORM, FPU_ROUND} fpu_state_t;

  typedef enum logic {FPU_OP_MUL, FPU_OP_ADD} fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

  // zero counts as one, anything above the array size is clamped
  function automatic logic [DimW-1:0] eff_dim(logic [CfgW-1:0] v, logic [DimW-1:0] max_dim);
    logic [DimW-1:0] ext;
    ext = DimW'(v);
    if (ext == '0) return DimW'(1);
    if (ext > max_dim) return max_dim;
    return ext;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fmm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module fmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fmm_fpu.sv =====
// shared binary32 multiply / add unit: operate, normalize, round; special operands finish after operate
// depends on fmm_pkg
`default_nettype none
module fmm_fpu (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fmm_pkg::fpu_req_t req,
  input  wire logic [31:0]      op_a,
  input  wire logic [31:0]      op_b,
  output fmm_pkg::fpu_rsp_t     rsp
);

  localparam int MW = 58;

  fmm_pkg::fpu_state_t state_r, state_nxt;

  logic                 done_r;
  logic [31:0]          res_r;
  logic                 sign_r;
  logic signed [11:0]   e_r;
  logic [MW-1:0]        m_r;
  logic signed [11:0]   sh_r;

  // operate stage
  logic        sa, sb;
  logic [7:0]  ea, eb, ea1, eb1;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0] ma, mb;
  logic [47:0] mprod;
  logic        spec_hit;
  logic [31:0] spec_val;
  logic        sign_c;
  logic signed [11:0] e_c;
  logic [MW-1:0] m_c;
  logic [23:0] xm, ym;
  logic [7:0]  ex, ey;
  logic        sx, sy;
  logic [7:0]  d;
  logic [5:0]  dcl;
  logic [55:0] x56, y56, yal;

  always_comb begin
    sa = op_a[31];
    sb = op_b[31];
    ea = op_a[30:23];
    eb = op_b[30:23];
    fa = op_a[22:0];
    fb = op_b[22:0];
    nan_a  = (ea == 8'hFF) && (fa != '0);
    nan_b  = (eb == 8'hFF) && (fb != '0);
    inf_a  = (ea == 8'hFF) && (fa == '0);
    inf_b  = (eb == 8'hFF) && (fb == '0);
    zero_a = (ea == '0) && (fa == '0);
    zero_b = (eb == '0) && (fb == '0);
    ma  = (ea != '0) ? {1'b1, fa} : {1'b0, fa};
    mb  = (eb != '0) ? {1'b1, fb} : {1'b0, fb};
    ea1 = (ea != '0) ? ea : 8'd1;
    eb1 = (eb != '0) ? eb : 8'd1;
    mprod = ma * mb;
    spec_hit = 1'b0;
    spec_val = fmm_pkg::FpPosZero;
    sign_c = 1'b0;
    e_c = '0;
    m_c = '0;
    sx = sa; sy = sb; xm = ma; ym = mb; ex = ea1; ey = eb1;
    d = '0; dcl = '0; x56 = '0; y56 = '0; yal = '0;
    if (req.op == fmm_pkg::FPU_OP_MUL) begin
      sign_c = sa ^ sb;
      if (nan_a || nan_b) begin
        spec_hit = 1'b1;
        spec_val = fmm_pkg::FpQnan;
      end else if (inf_a || inf_b) begin
        spec_hit = 1'b1;
        spec_val = (zero_a || zero_b) ? fmm_pkg::FpQnan : ({sign_c, 31'b0} | fmm_pkg::FpInf);
      end else if (zero_a || zero_b) begin
        spec_hit = 1'b1;
        spec_val = {sign_c, 31'b0};
      end
      e_c = $signed({4'b0, ea1}) + $signed({4'b0, eb1}) - 12'sd300;
      m_c = MW'(mprod);
    end else begin
      if (nan_a || nan_b) begin
        spec_hit = 1'b1;
        spec_val = fmm_pkg::FpQnan;
      end else if (inf_a) begin
        spec_hit = 1'b1;
        spec_val = (inf_b && (sa != sb)) ? fmm_pkg::FpQnan : op_a;
      end else if (inf_b) begin
        spec_hit = 1'b1;
        spec_val = op_b;
      end else if (zero_a) begin
        spec_hit = 1'b1;
        spec_val = zero_b ? {sa & sb, 31'b0} : op_b;
      end else if (zero_b) begin
        spec_hit = 1'b1;
        spec_val = op_a;
      end
      // larger exponent goes to x
      if (eb1 > ea1) begin
        sx = sb; sy = sa; xm = mb; ym = ma; ex = eb1; ey = ea1;
      end
      d   = ex - ey;
      dcl = (d > 8'd56) ? 6'd56 : d[5:0];
      x56 = {xm, 32'b0};
      y56 = {ym, 32'b0};
      yal = (y56 >> dcl) | 56'((y56 & ((56'b1 << dcl) - 56'b1)) != '0);
      e_c = $signed({4'b0, ex}) - 12'sd182;
      if (sx == sy) begin
        sign_c = sx;
        m_c = MW'(x56) + MW'(yal);
      end else if (x56 > yal) begin
        sign_c = sx;
        m_c = MW'(x56 - yal);
      end else if (yal > x56) begin
        sign_c = sy;
        m_c = MW'(yal - x56);
      end else if (!spec_hit) begin
        spec_hit = 1'b1;
        spec_val = fmm_pkg::FpPosZero;
      end
    end
  end

  // normalize stage: leading one position and the final right shift
  logic [5:0]         lead;
  logic signed [11:0] sh_lead, sh_lo;

  always_comb begin
    lead = '0;
    for (int n = 0; n < MW; n++) begin
      if (m_r[n]) lead = 6'(n);
    end
    sh_lead = $signed({6'b0, lead}) - 12'sd23;
    sh_lo   = -12'sd149 - e_r;
  end

  // round stage
  logic [MW-1:0]      lsh_q;
  logic [5:0]         rs;
  logic [MW+58:0]     full;
  logic [24:0]        q25, qr, qf;
  logic               inc;
  logic signed [11:0] r, rf;
  logic [31:0]        rnd_val;

  always_comb begin
    lsh_q = '0;
    full  = '0;
    rs    = '0;
    inc   = 1'b0;
    if (sh_r <= 12'sd0) begin
      lsh_q = m_r << 6'(-sh_r);
      q25   = lsh_q[24:0];
    end else begin
      rs   = (sh_r > 12'sd59) ? 6'd59 : sh_r[5:0];
      full = {m_r, 59'b0} >> rs;
      q25  = full[83:59];
      inc  = full[58] & ((|full[57:0]) | full[59]);
    end
    qr = q25 + 25'(inc);
    r  = e_r + sh_r;
    if (qr[24]) begin
      qf = qr >> 1;
      rf = r + 12'sd1;
    end else begin
      qf = qr;
      rf = r;
    end
    if (!qf[23]) begin
      rnd_val = {sign_r, 8'b0, qf[22:0]};
    end else if (rf >= 12'sd105) begin
      rnd_val = {sign_r, 31'b0} | fmm_pkg::FpInf;
    end else begin
      rnd_val = {sign_r, 8'(rf + 12'sd150), qf[22:0]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fmm_pkg::FPU_IDLE:  if (req.start && !spec_hit) state_nxt = fmm_pkg::FPU_NORM;
      fmm_pkg::FPU_NORM:  state_nxt = fmm_pkg::FPU_ROUND;
      fmm_pkg::FPU_ROUND: state_nxt = fmm_pkg::FPU_IDLE;
      default:            state_nxt = fmm_pkg::FPU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmm_pkg::FPU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == fmm_pkg::FPU_IDLE) && req.start && spec_hit) ||
                 (state_r == fmm_pkg::FPU_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fmm_pkg::FPU_IDLE && req.start) begin
      res_r  <= spec_val;
      sign_r <= sign_c;
      e_r    <= e_c;
      m_r    <= m_c;
    end
    if (state_r == fmm_pkg::FPU_NORM) begin
      sh_r <= (sh_lo > sh_lead) ? sh_lo : sh_lead;
    end
    if (state_r == fmm_pkg::FPU_ROUND) begin
      res_r <= rnd_val;
    end
  end

  always_comb begin
    rsp.done   = done_r;
    rsp.result = res_r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fmm_seq.sv =====
// sequencer: walks rows, columns and the inner index, drives the fpu, holds the result register
// depends on fmm_pkg and the assertion macro header
`default_nettype none
`include "float_matrix_multiply_core_defines.svh"
module fmm_seq #(
  parameter int MAX_DIM = fmm_pkg::MaxDimDefault,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW = $clog2((MAX_DIM * MAX_DIM) > 1 ? (MAX_DIM * MAX_DIM) : 2)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [fmm_pkg::DimW-1:0]  nr,
  input  wire logic [fmm_pkg::DimW-1:0]  ni,
  input  wire logic [fmm_pkg::DimW-1:0]  nc,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_func,
  output logic [AW-1:0]                  left_raddr,
  output logic [AW-1:0]                  right_raddr,
  input  wire logic [31:0]               left_rdata,
  input  wire logic [31:0]               right_rdata,
  output fmm_pkg::fpu_req_t              fpu_req,
  output logic [31:0]                    fpu_a,
  output logic [31:0]                    fpu_b,
  input  wire fmm_pkg::fpu_rsp_t         fpu_rsp,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [1:0]                     out_row,
  output logic [1:0]                     out_col,
  output logic [31:0]                    out_product,
  output logic                           out_last
);

  fmm_pkg::seq_state_t state_r, state_nxt;

  logic [IW-1:0] i_r, j_r, k_r;
  logic [31:0]   acc_r, prod_r;
  logic          out_valid_r;
  logic [1:0]    out_row_r, out_col_r;
  logic [31:0]   out_product_r;
  logic          out_last_r;

  logic start_compute, k_last, j_last, i_last, can_emit, emit;

  always_comb begin
    start_compute = in_valid && in_ready && (in_func == fmm_pkg::FuncCompute);
    k_last   = (fmm_pkg::DimW'(k_r) == ni - fmm_pkg::DimW'(1));
    j_last   = (fmm_pkg::DimW'(j_r) == nc - fmm_pkg::DimW'(1));
    i_last   = (fmm_pkg::DimW'(i_r) == nr - fmm_pkg::DimW'(1));
    can_emit = !out_valid_r || out_ready;
    emit     = (state_r == fmm_pkg::SEQ_EMIT) && can_emit;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fmm_pkg::SEQ_IDLE:     if (start_compute) state_nxt = fmm_pkg::SEQ_READ;
      fmm_pkg::SEQ_READ:     state_nxt = fmm_pkg::SEQ_MUL;
      fmm_pkg::SEQ_MUL:      state_nxt = fmm_pkg::SEQ_MUL_WAIT;
      fmm_pkg::SEQ_MUL_WAIT: if (fpu_rsp.done) state_nxt = fmm_pkg::SEQ_ADD;
      fmm_pkg::SEQ_ADD:      state_nxt = fmm_pkg::SEQ_ADD_WAIT;
      fmm_pkg::SEQ_ADD_WAIT: begin
        if (fpu_rsp.done) state_nxt = k_last ? fmm_pkg::SEQ_EMIT : fmm_pkg::SEQ_READ;
      end
      fmm_pkg::SEQ_EMIT: begin
        if (can_emit) state_nxt = (i_last && j_last) ? fmm_pkg::SEQ_IDLE : fmm_pkg::SEQ_READ;
      end
      default: state_nxt = fmm_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == fmm_pkg::SEQ_IDLE);
    fpu_req.start = (state_r == fmm_pkg::SEQ_MUL) || (state_r == fmm_pkg::SEQ_ADD);
    fpu_req.op    = (state_r == fmm_pkg::SEQ_ADD) ? fmm_pkg::FPU_OP_ADD : fmm_pkg::FPU_OP_MUL;
    fpu_a         = (state_r == fmm_pkg::SEQ_ADD) ? acc_r : left_rdata;
    fpu_b         = (state_r == fmm_pkg::SEQ_ADD) ? prod_r : right_rdata;
    left_raddr    = AW'(int'(i_r) * MAX_DIM + int'(k_r));
    right_raddr   = AW'(int'(k_r) * MAX_DIM + int'(j_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmm_pkg::SEQ_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (start_compute) begin
        i_r <= '0;
        j_r <= '0;
        k_r <= '0;
      end else if ((state_r == fmm_pkg::SEQ_ADD_WAIT) && fpu_rsp.done && !k_last) begin
        k_r <= k_r + IW'(1);
      end else if (emit) begin
        k_r <= '0;
        if (j_last) begin
          j_r <= '0;
          i_r <= i_r + IW'(1);
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_compute || emit) begin
      acc_r <= fmm_pkg::FpPosZero;
    end else if ((state_r == fmm_pkg::SEQ_ADD_WAIT) && fpu_rsp.done) begin
      acc_r <= fpu_rsp.result;
    end
    if ((state_r == fmm_pkg::SEQ_MUL_WAIT) && fpu_rsp.done) begin
      prod_r <= fpu_rsp.result;
    end
    if (emit) begin
      out_row_r     <= 2'(i_r);
      out_col_r     <= 2'(j_r);
      out_product_r <= acc_r;
      out_last_r    <= i_last && j_last;
    end
  end

  always_comb begin
    out_valid   = out_valid_r;
    out_row     = out_row_r;
    out_col     = out_col_r;
    out_product = out_product_r;
    out_last    = out_last_r;
  end

  `FMM_ASSERT_NOW(a_done_when_waiting, fpu_rsp.done,
    (state_r == fmm_pkg::SEQ_MUL_WAIT) || (state_r == fmm_pkg::SEQ_ADD_WAIT),
    "fpu result arrived while the sequencer was not waiting")
  `FMM_ASSERT_NEXT(a_compute_starts, start_compute, state_r == fmm_pkg::SEQ_READ,
    "compute transfer did not start the first read")
  `FMM_ASSERT_NOW(a_inner_bound, state_r != fmm_pkg::SEQ_IDLE,
    fmm_pkg::DimW'(k_r) < ni, "inner index ran past the inner size")

endmodule
`default_nettype wire

// ===== hw/rtl/float_matrix_multiply_core.sv =====
// Float matrix multiply core, binary32 round-to-nearest-even, subnormals kept. Load transfers
// (func 0 left, func 1 right) write the element rams; a compute transfer streams the product in
// row-major order with out_last on the final element. Every element costs inner_size passes
// of a shared fpu, each pass a read, a multiply and an add; the element then ends in an emit,
// which waits while the output register is held. in_ready is low from a compute transfer until
// its last element sits in the output register. Dimension registers sit at APB addresses 0, 4
// and 8 and may be written only while idle.
// top level: apb registers, the two element rams, the fpu and the sequencer
// depends on fmm_pkg, fmm_ram, fmm_fpu, fmm_seq
`default_nettype none
module float_matrix_multiply_core #(
  parameter int MAX_DIM = fmm_pkg::MaxDimDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fmm_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_func,
  input  wire logic [1:0]                  in_row,
  input  wire logic [1:0]                  in_col,
  input  wire logic [31:0]                 in_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_row,
  output logic [1:0]                       out_col,
  output logic [31:0]                      out_product,
  output logic                             out_last
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(Depth > 1 ? Depth : 2);

  logic [fmm_pkg::CfgW-1:0] left_rows_r, inner_size_r, right_cols_r;
  logic [fmm_pkg::DimW-1:0] nr, ni, nc;
  logic                     cfg_wr;
  logic                     in_xfer, left_we, right_we;
  logic [AW-1:0]            waddr, left_raddr, right_raddr;
  logic [31:0]              left_rdata, right_rdata, fpu_a, fpu_b;
  fmm_pkg::fpu_req_t        fpu_req;
  fmm_pkg::fpu_rsp_t        fpu_rsp;

  always_comb begin
    pready = 1'b1;
    cfg_wr = psel && penable && pwrite;
    unique case (paddr[3:2])
      fmm_pkg::RegLeftRows:  prdata = 32'(left_rows_r);
      fmm_pkg::RegInnerSize: prdata = 32'(inner_size_r);
      fmm_pkg::RegRightCols: prdata = 32'(right_cols_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_rows_r  <= fmm_pkg::DimReset;
      inner_size_r <= fmm_pkg::DimReset;
      right_cols_r <= fmm_pkg::DimReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fmm_pkg::RegLeftRows:  left_rows_r  <= pwdata[fmm_pkg::CfgW-1:0];
        fmm_pkg::RegInnerSize: inner_size_r <= pwdata[fmm_pkg::CfgW-1:0];
        fmm_pkg::RegRightCols: right_cols_r <= pwdata[fmm_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nr = fmm_pkg::eff_dim(left_rows_r, fmm_pkg::DimW'(MAX_DIM));
    ni = fmm_pkg::eff_dim(inner_size_r, fmm_pkg::DimW'(MAX_DIM));
    nc = fmm_pkg::eff_dim(right_cols_r, fmm_pkg::DimW'(MAX_DIM));
    in_xfer  = in_valid && in_ready;
    // loads outside the current dimensions are dropped
    left_we  = in_xfer && (in_func == fmm_pkg::FuncLoadLeft) &&
               (fmm_pkg::DimW'(in_row) < nr) && (fmm_pkg::DimW'(in_col) < ni);
    right_we = in_xfer && (in_func == fmm_pkg::FuncLoadRight) &&
               (fmm_pkg::DimW'(in_row) < ni) && (fmm_pkg::DimW'(in_col) < nc);
    waddr    = AW'(int'(in_row) * MAX_DIM + int'(in_col));
  end

  fmm_ram #(.WIDTH(32), .DEPTH(Depth)) u_left_ram (
    .clk   (clk),
    .we    (left_we),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  fmm_ram #(.WIDTH(32), .DEPTH(Depth)) u_right_ram (
    .clk   (clk),
    .we    (right_we),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  fmm_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .op_a  (fpu_a),
    .op_b  (fpu_b),
    .rsp   (fpu_rsp)
  );

  fmm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .nr          (nr),
    .ni          (ni),
    .nc          (nc),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .left_raddr  (left_raddr),
    .right_raddr (right_raddr),
    .left_rdata  (left_rdata),
    .right_rdata (right_rdata),
    .fpu_req     (fpu_req),
    .fpu_a       (fpu_a),
    .fpu_b       (fpu_b),
    .fpu_rsp     (fpu_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_product (out_product),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire
